@@ rtl/dtcd_pkg.sv @@
package dtcd_pkg;

  // Widths fixed by the item and result formats.
  localparam int PosWidth     = 8;
  localparam int SlotWidth    = 5;
  localparam int CountWidth   = 6;
  localparam int ResultsMax   = 3;
  localparam int QueueDepth   = 2;

  // Event kinds on the result side.
  localparam logic EvChar = 1'b0;
  localparam logic EvTerm = 1'b1;

  // One classified input byte, as it travels from the front to the back.
  typedef struct packed {
    logic       start;    // first byte of a message
    logic       buf_end;  // last byte of the buffer
    logic [1:0] nchars;   // characters to write: 0, 1 or 2
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic       term;     // close the current chunk
    logic       stop;     // stop parsing after this byte
    logic       skip;     // skip the following byte
  } item_t;

  // One result beat.
  typedef struct packed {
    logic                  kind;
    logic [SlotWidth-1:0]  slot;
    logic [PosWidth-1:0]   pos;
    logic [7:0]            data;
    logic [CountWidth-1:0] count;
    logic                  stopped;
    logic                  last;
  } result_t;

endpackage

@@ rtl/dtcd_front.sv @@
module dtcd_front (
  input  logic            encoding_mode,
  input  logic [7:0]      text_byte,
  input  logic            message_start,
  input  logic            buffer_end,
  output dtcd_pkg::item_t item
);
  import dtcd_pkg::*;

  // Command codes of the first encoding.
  localparam logic [7:0] M0CmdBase    = 8'h67;
  localparam logic [7:0] M0LtGlyph    = 8'h5A;
  localparam logic [7:0] M0SkipLoA    = 8'h6B;
  localparam logic [7:0] M0SkipHiA    = 8'h6E;
  localparam logic [7:0] M0SpaceLo    = 8'h73;
  localparam logic [7:0] M0SpaceHi    = 8'h76;
  localparam logic [7:0] M0SkipLoB    = 8'h77;
  localparam logic [7:0] M0SkipHiB    = 8'h7A;
  localparam logic [7:0] M0Wait       = 8'h7E;
  localparam logic [7:0] CodeEnd      = 8'h7F;
  localparam logic [7:0] M0Invalid    = 8'h80;
  // Codes of the second encoding.
  localparam logic [7:0] M1AccentBase = 8'h5A;
  localparam logic [7:0] M1CmdBase    = 8'h70;
  localparam logic [7:0] M1Space      = 8'h80;
  localparam logic [7:0] M1Wait       = 8'h81;
  localparam logic [7:0] M1SpaceLo    = 8'h82;
  localparam logic [7:0] M1SpaceHi    = 8'h86;
  localparam logic [7:0] M1Skip       = 8'h87;
  localparam logic [7:0] Utf8Lead     = 8'hC3;
  localparam logic [7:0] AsciiSpace   = 8'h20;
  localparam logic [7:0] AsciiLt      = 8'h3C;

  // Letters, digits and punctuation common to both encodings.
  function automatic logic [7:0] shared_char(input logic [7:0] c);
    logic [7:0] r;
    r = 8'h00;
    if (c < 8'd26) begin
      r = 8'h41 + c;
    end else if (c < 8'd52) begin
      r = 8'h61 + (c - 8'd26);
    end else if (c < 8'd62) begin
      r = 8'h30 + (c - 8'd52);
    end else begin
      case (c)
        8'h3E:   r = 8'h21;
        8'h3F:   r = 8'h3F;
        8'h40:   r = 8'h2D;
        8'h41:   r = 8'h2E;
        8'h42:   r = 8'h2C;
        8'h43:   r = 8'h2E;
        8'h44:   r = 8'h3E;
        8'h45:   r = 8'h28;
        8'h46:   r = 8'h29;
        8'h4C:   r = 8'h22;
        8'h51:   r = 8'h27;
        8'h59:   r = 8'h20;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  // Accent codes of the second encoding: values with the top bit set are
  // the trailing byte of a two-byte UTF-8 sequence.
  function automatic logic [7:0] accent_char(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h5A:   r = 8'hB6;
      8'h5F:   r = 8'hBC;
      8'h60:   r = 8'hB4;
      8'h61:   r = 8'h3A;
      8'h66:   r = 8'hA8;
      8'h67:   r = 8'hA9;
      8'h68:   r = 8'hAA;
      8'h69:   r = 8'hA0;
      8'h6A:   r = 8'hB9;
      8'h6B:   r = 8'hA7;
      8'h6C:   r = 8'hA2;
      8'h6D:   r = 8'hBB;
      8'h6E:   r = 8'hAE;
      8'h6F:   r = 8'hA4;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Classify the byte into characters to write and chunk commands.
  always_comb begin
    logic [7:0] ch;
    ch = 8'h00;
    item = '0;
    item.start   = message_start;
    item.buf_end = buffer_end;
    if (!encoding_mode) begin
      if (text_byte < M0CmdBase) begin
        ch = (text_byte == M0LtGlyph) ? AsciiLt : shared_char(text_byte);
        if (ch != 8'h00) begin
          item.nchars = 2'd1;
          item.ch0    = ch;
        end
      end else if (text_byte >= M0Invalid) begin
        item.stop = 1'b1;
      end else begin
        if (text_byte >= M0SpaceLo && text_byte <= M0SpaceHi) begin
          item.nchars = 2'd1;
          item.ch0    = AsciiSpace;
        end
        if (text_byte == M0Wait || text_byte == CodeEnd) begin
          item.term = 1'b1;
        end
        if (text_byte == CodeEnd) begin
          item.stop = 1'b1;
        end
        if ((text_byte >= M0SkipLoA && text_byte <= M0SkipHiA) ||
            (text_byte >= M0SkipLoB && text_byte <= M0SkipHiB)) begin
          item.skip = 1'b1;
        end
      end
    end else begin
      if (text_byte < M1AccentBase) begin
        ch = shared_char(text_byte);
        if (ch != 8'h00) begin
          item.nchars = 2'd1;
          item.ch0    = ch;
        end
      end else if (text_byte < M1CmdBase) begin
        ch = accent_char(text_byte);
        if (ch[7]) begin
          item.nchars = 2'd2;
          item.ch0    = Utf8Lead;
          item.ch1    = ch;
        end else if (ch != 8'h00) begin
          item.nchars = 2'd1;
          item.ch0    = ch;
        end
      end else if (text_byte == CodeEnd) begin
        item.term = 1'b1;
        item.stop = 1'b1;
      end else if (text_byte == M1Space ||
                   (text_byte >= M1SpaceLo && text_byte <= M1SpaceHi)) begin
        item.nchars = 2'd1;
        item.ch0    = AsciiSpace;
      end else if (text_byte == M1Wait) begin
        item.term = 1'b1;
      end else if (text_byte == M1Skip) begin
        item.skip = 1'b1;
      end
    end
  end

endmodule

@@ rtl/dtcd_queue.sv @@
module dtcd_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dtcd_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output dtcd_pkg::item_t out_item
);
  import dtcd_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  item_t           slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            push;
  logic            pop;

  assign in_ready  = (fill != CntFull);
  assign out_valid = (fill != '0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

@@ rtl/dtcd_back.sv @@
module dtcd_back #(
  parameter int NUM_CHUNKS  = 32,
  parameter int CHUNK_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dtcd_pkg::item_t   in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output dtcd_pkg::result_t out_result
);
  import dtcd_pkg::*;

  localparam int CW = $clog2(NUM_CHUNKS + 1);
  localparam logic [CW-1:0]       CntMax     = CW'(NUM_CHUNKS);
  localparam logic [CW-1:0]       CntTermMax = CW'(NUM_CHUNKS - 1);
  localparam logic [PosWidth-1:0] PosLimit   = PosWidth'(CHUNK_BYTES - 2);
  localparam int NCand = 4;

  function automatic logic [SlotWidth-1:0] slot_of(input logic [CW-1:0] v);
    logic [CW+SlotWidth-1:0] e;
    e = {{SlotWidth{1'b0}}, v};
    return e[SlotWidth-1:0];
  endfunction

  function automatic logic [CountWidth-1:0] count_of(input logic [CW-1:0] v);
    logic [CW+CountWidth-1:0] e;
    e = {{CountWidth{1'b0}}, v};
    return e[CountWidth-1:0];
  endfunction

  // Decoder state.
  logic [PosWidth-1:0] pos;
  logic [CW-1:0]       cnt;
  logic                skip;
  logic                stopped;
  logic [PosWidth-1:0] pos_next;
  logic [CW-1:0]       cnt_next;
  logic                skip_next;
  logic                stopped_next;

  // Result buffer for the byte being delivered.
  result_t   res [ResultsMax];
  result_t   plan [ResultsMax];
  logic [1:0] res_n;
  logic [1:0] res_idx;
  logic [1:0] plan_n;
  logic       take;
  logic       buf_free;
  logic       load;

  assign out_valid  = (res_idx < res_n);
  assign out_result = (res_idx == 2'd3) ? '0 : res[res_idx];
  assign take       = out_valid && out_ready;
  assign buf_free   = (res_idx == res_n) || (take && (res_idx == res_n - 2'd1));
  assign in_ready   = buf_free;
  assign load       = in_valid && buf_free;

  // Work out the state after the byte and the results it causes.
  always_comb begin
    logic [PosWidth-1:0] p;
    logic [CW-1:0]       c;
    logic                s;
    logic                st;
    logic                halt;
    logic [NCand-1:0]    cv;
    result_t             cand [NCand];
    logic [1:0]          n;
    p    = pos;
    c    = cnt;
    s    = skip;
    st   = stopped;
    halt = 1'b0;
    cv   = '0;
    n    = 2'd0;
    for (int i = 0; i < NCand; i++) begin
      cand[i] = '0;
    end
    for (int k = 0; k < ResultsMax; k++) begin
      plan[k] = '0;
    end
    if (in_item.start) begin
      p  = '0;
      c  = '0;
      s  = 1'b0;
      st = 1'b0;
    end
    if (!st) begin
      if (s) begin
        s = 1'b0;
      end else begin
        // Character writes, each held back at the position limit.
        if (in_item.nchars != 2'd0 && p < PosLimit) begin
          cv[0]         = 1'b1;
          cand[0].kind  = EvChar;
          cand[0].slot  = slot_of(c);
          cand[0].pos   = p;
          cand[0].data  = in_item.ch0;
          cand[0].count = count_of(c);
          p             = p + PosWidth'(1);
        end
        if (in_item.nchars == 2'd2 && p < PosLimit) begin
          cv[1]         = 1'b1;
          cand[1].kind  = EvChar;
          cand[1].slot  = slot_of(c);
          cand[1].pos   = p;
          cand[1].data  = in_item.ch1;
          cand[1].count = count_of(c);
          p             = p + PosWidth'(1);
        end
        // Terminator command: reported even for an empty chunk.
        if (in_item.term) begin
          cv[2]        = 1'b1;
          cand[2].kind = EvTerm;
          cand[2].slot = slot_of(c);
          cand[2].pos  = p;
          if (p != '0 && c < CntTermMax) begin
            c = c + CW'(1);
          end
          cand[2].count = count_of(c);
          p             = '0;
        end
        s    = in_item.skip;
        halt = in_item.stop;
      end
      // Closing flush when parsing stops or the buffer ends.
      if (halt || in_item.buf_end) begin
        if (p != '0 && c < CntMax) begin
          cv[3]         = 1'b1;
          cand[3].kind  = EvTerm;
          cand[3].slot  = slot_of(c);
          cand[3].pos   = p;
          c             = c + CW'(1);
          cand[3].count = count_of(c);
        end
        p  = '0;
        st = 1'b1;
      end
    end
    // Pack the events in order.
    for (int i = 0; i < NCand; i++) begin
      if (cv[i] && n != 2'd3) begin
        plan[n] = cand[i];
        n       = n + 2'd1;
      end
    end
    for (int k = 0; k < ResultsMax; k++) begin
      plan[k].stopped = st;
      plan[k].last    = (2'(k) == n - 2'd1);
    end
    plan_n       = n;
    pos_next     = p;
    cnt_next     = c;
    skip_next    = s;
    stopped_next = st;
  end

  // State and delivery control.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      cnt     <= '0;
      skip    <= 1'b0;
      stopped <= 1'b0;
      res_n   <= 2'd0;
      res_idx <= 2'd0;
    end else if (load) begin
      pos     <= pos_next;
      cnt     <= cnt_next;
      skip    <= skip_next;
      stopped <= stopped_next;
      res_n   <= plan_n;
      res_idx <= 2'd0;
    end else if (take) begin
      res_idx <= res_idx + 2'd1;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < ResultsMax; k++) begin
        res[k] <= plan[k];
      end
    end
  end

endmodule

@@ rtl/dialog_text_chunk_decoder.sv @@
// A byte taken passes through the queue register, then the result register, before
// its first result beat appears. Throughput: one byte per cycle while each byte yields
// at most one result and m_tready is high; the result register sends one beat per
// cycle while m_tready is high, and the next byte loads as the last beat is taken.
// A two-entry queue between the classifier and the chunk sequencer absorbs stalls.
// Reset (rst, synchronous) clears position, chunk count, skip and stop flags,
// empties the queue and sets the encoding mode to the first encoding.
module dialog_text_chunk_decoder #(
  parameter int NUM_CHUNKS  = 32,
  parameter int CHUNK_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte
  input  logic [0:0]  s_tuser,   // message_start
  input  logic        s_tlast,   // buffer_end
  output logic        m_tvalid,
  input  logic        m_tready,
  // chunk_index[4:0], char_pos[12:5], char_byte[20:13], chunk_count[26:21],
  // parse_stopped[27], zero fill [31:28]
  output logic [31:0] m_tdata,
  output logic [0:0]  m_tuser,   // event_kind
  output logic        m_tlast    // last_of_run
);
  import dtcd_pkg::*;

  logic    encoding_mode;
  item_t   front_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  result_t result;

  // Encoding mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_mode <= 1'b0;
    end else if (cfg_we) begin
      encoding_mode <= cfg_wdata;
    end
  end

  // Classify each incoming beat.
  dtcd_front u_front (
    .encoding_mode (encoding_mode),
    .text_byte     (s_tdata),
    .message_start (s_tuser[0]),
    .buffer_end    (s_tlast),
    .item          (front_item)
  );

  // Decouple the classifier from the sequencer.
  dtcd_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (front_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // Chunk state and result delivery.
  dtcd_back #(
    .NUM_CHUNKS  (NUM_CHUNKS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_item    (q_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  // Pack the result beat.
  assign m_tdata = {4'b0000, result.stopped, result.count, result.data,
                    result.pos, result.slot};
  assign m_tuser = result.kind;
  assign m_tlast = result.last;

endmodule

@@ test/dialog_text_chunk_decoder_tb.sv @@
module dialog_text_chunk_decoder_tb;
  import dtcd_pkg::*;

  localparam int NUM_CHUNKS    = 32;
  localparam int CHUNK_BYTES   = 256;
  localparam int CHAR_LIMIT    = CHUNK_BYTES - 2;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 330;
  localparam int PHASE_ITEMS   = 60;
  localparam int MAX_REPORTS   = 10;
  localparam int RUN_LIMIT     = 2000000;

  // Encoding selections.
  localparam logic MODE_TABLE = 1'b0;
  localparam logic MODE_UTF8  = 1'b1;

  // Command codes shared by both encodings or specific to one.
  localparam logic [7:0] CMD_END        = 8'h7F;
  localparam logic [7:0] CMD0_FIRST     = 8'h67;
  localparam logic [7:0] CMD0_SKIP_A_LO = 8'h6B;
  localparam logic [7:0] CMD0_SKIP_A_HI = 8'h6E;
  localparam logic [7:0] CMD0_SPACE_LO  = 8'h73;
  localparam logic [7:0] CMD0_SPACE_HI  = 8'h76;
  localparam logic [7:0] CMD0_SKIP_B_LO = 8'h77;
  localparam logic [7:0] CMD0_SKIP_B_HI = 8'h7A;
  localparam logic [7:0] CMD0_WAIT      = 8'h7E;
  localparam logic [7:0] CMD0_INVALID   = 8'h80;
  localparam logic [7:0] CODE0_ANGLE    = 8'h5A;
  localparam logic [7:0] CODE1_ACCENT   = 8'h5A;
  localparam logic [7:0] CODE1_PAIR_LO  = 8'h66;
  localparam logic [7:0] CMD1_FIRST_NOP = 8'h70;
  localparam logic [7:0] CMD1_SPACE     = 8'h80;
  localparam logic [7:0] CMD1_WAIT      = 8'h81;
  localparam logic [7:0] CMD1_SPACE_LO  = 8'h82;
  localparam logic [7:0] CMD1_SPACE_HI  = 8'h86;
  localparam logic [7:0] CMD1_SKIP      = 8'h87;
  localparam logic [7:0] UTF8_LEAD      = 8'hC3;

  // One directed row; a fixed row carries its own expectation.
  typedef struct packed {
    logic       mode;
    logic [7:0] text;
    logic       first;
    logic       fin;
    logic       fixed;
    logic       fixed_one;
    result_t    fixed_ev;
  } stim_row_t;

  localparam result_t NO_EVENT = '0;

  localparam stim_row_t DIRECTED [25] = '{
    '{MODE_TABLE, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1,
      '{EvChar, 5'd0, 8'd0, 8'h41, 6'd0, 1'b0, 1'b1}},
    '{MODE_TABLE, 8'h19, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_TABLE, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_TABLE, 8'h66, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_TABLE, 8'h3E, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_TABLE, 8'h73, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_TABLE, 8'h6B, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_TABLE, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_TABLE, 8'h7E, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_TABLE, 8'h7E, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_TABLE, 8'h1A, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_TABLE, 8'h80, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_TABLE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_TABLE, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, NO_EVENT},
    '{MODE_UTF8,  8'h5A, 1'b1, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_UTF8,  8'h61, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_UTF8,  8'h70, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_UTF8,  8'h80, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_UTF8,  8'h86, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_UTF8,  8'h81, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_UTF8,  8'h05, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_UTF8,  8'h87, 1'b0, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{MODE_UTF8,  8'h7F, 1'b0, 1'b1, 1'b0, 1'b0, NO_EVENT},
    '{MODE_UTF8,  8'h7F, 1'b1, 1'b0, 1'b1, 1'b1,
      '{EvTerm, 5'd0, 8'd0, 8'h00, 6'd0, 1'b1, 1'b1}},
    '{MODE_UTF8,  8'h6F, 1'b1, 1'b1, 1'b0, 1'b0, NO_EVENT}
  };

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic [0:0]  s_tuser   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  // Shadow decoder state.
  logic pred_mode    = MODE_TABLE;
  int   pred_pos     = 0;
  int   pred_count   = 0;
  logic pred_skip    = 1'b0;
  logic pred_stopped = 1'b0;

  result_t step_events[$];
  result_t expected_events[$];

  bit hold_prediction = 1'b0;
  bit src_idle_on     = 1'b1;
  bit sink_idle_on    = 1'b1;

  int mismatches    = 0;
  int beats_checked = 0;
  int closes_seen   = 0;
  int live_items    = 0;
  int dropped_bytes = 0;
  int mode_writes   = 0;

  dialog_text_chunk_decoder #(
    .NUM_CHUNKS (NUM_CHUNKS),
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Letters, digits and punctuation common to both encodings.
  function automatic logic [7:0] common_glyph(logic [7:0] c);
    if (c < 8'd26) return 8'h41 + c;
    if (c < 8'd52) return 8'h61 + (c - 8'd26);
    if (c < 8'd62) return 8'h30 + (c - 8'd52);
    case (c)
      8'h3E: return "!";
      8'h3F: return "?";
      8'h40: return "-";
      8'h41: return ".";
      8'h42: return ",";
      8'h43: return ".";
      8'h44: return ">";
      8'h45: return "(";
      8'h46: return ")";
      8'h4C: return 8'h22;
      8'h51: return 8'h27;
      8'h59: return " ";
      default: return 8'h00;
    endcase
  endfunction

  // Accent codes of the second encoding; values from 0x80 up are the
  // trailing byte of a two-byte UTF-8 sequence.
  function automatic logic [7:0] accent_glyph(logic [7:0] c);
    case (c)
      8'h5A: return 8'hB6;
      8'h5F: return 8'hBC;
      8'h60: return 8'hB4;
      8'h61: return ":";
      8'h66: return 8'hA8;
      8'h67: return 8'hA9;
      8'h68: return 8'hAA;
      8'h69: return 8'hA0;
      8'h6A: return 8'hB9;
      8'h6B: return 8'hA7;
      8'h6C: return 8'hA2;
      8'h6D: return 8'hBB;
      8'h6E: return 8'hAE;
      8'h6F: return 8'hA4;
      default: return 8'h00;
    endcase
  endfunction

  function automatic void post_event(logic kind, int slot, int pos, logic [7:0] data);
    result_t r;
    r.kind    = kind;
    r.slot    = SlotWidth'(slot);
    r.pos     = PosWidth'(pos);
    r.data    = data;
    r.count   = CountWidth'(pred_count);
    r.stopped = 1'b0;
    r.last    = 1'b0;
    step_events.push_back(r);
  endfunction

  function automatic void write_char(logic [7:0] ch);
    if (pred_pos < CHAR_LIMIT) begin
      post_event(EvChar, pred_count, pred_pos, ch);
      pred_pos++;
    end else begin
      dropped_bytes++;
    end
  endfunction

  // A wait or end command always reports a terminator, even on an empty chunk.
  function automatic void close_chunk();
    int slot;
    slot = pred_count;
    if (pred_pos > 0 && pred_count < NUM_CHUNKS - 1) pred_count++;
    post_event(EvTerm, slot, pred_pos, 8'h00);
    pred_pos = 0;
  endfunction

  // The closing flush reports only a non-empty chunk while slots remain.
  function automatic void flush_chunk();
    int slot;
    if (pred_pos > 0 && pred_count < NUM_CHUNKS) begin
      slot = pred_count;
      pred_count++;
      post_event(EvTerm, slot, pred_pos, 8'h00);
    end
    pred_pos = 0;
  endfunction

  function automatic bit decode_plain_table(logic [7:0] c);
    logic [7:0] ch;
    if (c < CMD0_FIRST) begin
      ch = (c == CODE0_ANGLE) ? 8'h3C : common_glyph(c);
      if (ch != 8'h00) write_char(ch);
      return 1'b0;
    end
    if (c >= CMD0_INVALID) return 1'b1;
    if (c >= CMD0_SPACE_LO && c <= CMD0_SPACE_HI) write_char(" ");
    if (c == CMD0_WAIT || c == CMD_END) begin
      close_chunk();
      if (c == CMD_END) return 1'b1;
    end
    pred_skip = (c >= CMD0_SKIP_A_LO && c <= CMD0_SKIP_A_HI) ||
                (c >= CMD0_SKIP_B_LO && c <= CMD0_SKIP_B_HI);
    return 1'b0;
  endfunction

  function automatic bit decode_utf8_table(logic [7:0] c);
    logic [7:0] v;
    if (c < CODE1_ACCENT) begin
      v = common_glyph(c);
      if (v != 8'h00) write_char(v);
    end else if (c < CMD1_FIRST_NOP) begin
      v = accent_glyph(c);
      if (v >= 8'h80) begin
        write_char(UTF8_LEAD);
        write_char(v);
      end else if (v != 8'h00) begin
        write_char(v);
      end
    end else if (c == CMD_END) begin
      close_chunk();
      return 1'b1;
    end else if (c == CMD1_SPACE || (c >= CMD1_SPACE_LO && c <= CMD1_SPACE_HI)) begin
      write_char(" ");
    end else if (c == CMD1_WAIT) begin
      close_chunk();
    end else if (c == CMD1_SKIP) begin
      pred_skip = 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the result beats of one accepted input beat.
  function automatic void decode_step(logic [7:0] text, logic first, logic fin);
    bit halt;
    halt = 1'b0;
    step_events.delete();
    if (first) begin
      pred_pos     = 0;
      pred_count   = 0;
      pred_skip    = 1'b0;
      pred_stopped = 1'b0;
    end
    if (pred_stopped) return;
    live_items++;
    if (pred_skip) pred_skip = 1'b0;
    else if (pred_mode == MODE_UTF8) halt = decode_utf8_table(text);
    else halt = decode_plain_table(text);
    if (halt || fin) begin
      flush_chunk();
      pred_stopped = 1'b1;
    end
    foreach (step_events[k]) begin
      step_events[k].stopped = pred_stopped;
      step_events[k].last    = (k == step_events.size() - 1);
      if (!hold_prediction) expected_events.push_back(step_events[k]);
    end
  endfunction

  function automatic string event_text(result_t r);
    return $sformatf("kind %0d slot %0d pos %0d byte %02h count %0d stopped %0d last %0d",
                     r.kind, r.slot, r.pos, r.data, r.count, r.stopped, r.last);
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Body byte of a well-formed message, weighted toward characters.
  function automatic logic [7:0] pick_body_byte(logic mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == MODE_TABLE) begin
      if (r < 62) return 8'($urandom_range(0, 8'h66));
      if (r < 72) return 8'($urandom_range(CMD0_SPACE_LO, CMD0_SPACE_HI));
      if (r < 80) return CMD0_WAIT;
      if (r < 87) begin
        if ($urandom_range(0, 1) == 0)
          return 8'($urandom_range(CMD0_SKIP_A_LO, CMD0_SKIP_A_HI));
        return 8'($urandom_range(CMD0_SKIP_B_LO, CMD0_SKIP_B_HI));
      end
      if (r < 97) begin
        case ($urandom_range(0, 2))
          0: return 8'($urandom_range(CMD0_FIRST, CMD0_SKIP_A_LO - 1));
          1: return 8'($urandom_range(CMD0_SKIP_A_HI + 1, CMD0_SPACE_LO - 1));
          default: return 8'($urandom_range(CMD0_SKIP_B_HI + 1, CMD0_WAIT - 1));
        endcase
      end
      return 8'($urandom_range(CMD0_INVALID, 8'hFF));
    end
    if (r < 60) return 8'($urandom_range(0, CODE1_ACCENT - 1));
    if (r < 72) return 8'($urandom_range(CODE1_ACCENT, CMD1_FIRST_NOP - 1));
    if (r < 80) begin
      if ($urandom_range(0, 5) == 0) return CMD1_SPACE;
      return 8'($urandom_range(CMD1_SPACE_LO, CMD1_SPACE_HI));
    end
    if (r < 87) return CMD1_WAIT;
    if (r < 92) return CMD1_SKIP;
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(CMD1_FIRST_NOP, CMD_END - 1));
    return 8'($urandom_range(CMD1_SKIP + 1, 8'hFF));
  endfunction

  // Sends one input beat, with a random idle gap before it; called at a clock edge.
  task automatic send_beat(input logic [7:0] text, input logic first, input logic fin);
    int gap;
    gap = 0;
    if (src_idle_on) while ($urandom_range(0, 99) < 25) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= text;
    s_tuser  <= first;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    decode_step(text, first, fin);
  endtask

  // Mode changes only once every expected beat is out and the pipeline is quiet.
  task automatic set_encoding(input logic mode);
    s_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pred_mode = mode;
    mode_writes++;
  endtask

  // Well-formed message with random content, or a burst of raw noise.
  task automatic send_message(input bit noisy);
    int  len;
    bit  by_flag;
    len     = $urandom_range(2, 24);
    by_flag = $urandom_range(0, 1);
    if (noisy) begin
      for (int i = 0; i < len; i++)
        send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                  $urandom_range(0, 15) == 0);
    end else begin
      for (int i = 0; i < len; i++)
        send_beat(pick_body_byte(pred_mode), i == 0, by_flag && i == len - 1);
      if (!by_flag) send_beat(CMD_END, 1'b0, 1'b0);
      if ($urandom_range(0, 3) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
  endtask

  // Fills one chunk past the position limit, with UTF-8 pairs and single characters in equal measure.
  task automatic send_long_message();
    int extra;
    extra = 0;
    send_beat(8'h00, 1'b1, 1'b0);
    while (pred_pos < CHAR_LIMIT || extra < 6) begin
      if (pred_pos >= CHAR_LIMIT) extra++;
      if ($urandom_range(0, 1) == 0)
        send_beat(8'($urandom_range(CODE1_PAIR_LO, CMD1_FIRST_NOP - 1)), 1'b0, 1'b0);
      else
        send_beat(8'($urandom_range(0, 8'h3D)), 1'b0, 1'b0);
    end
    send_beat(CMD_END, 1'b0, 1'b0);
  endtask

  // Many one-character chunks so that the chunk count saturates.
  task automatic send_chunk_run();
    send_beat(8'($urandom_range(0, 8'h33)), 1'b1, 1'b0);
    repeat (NUM_CHUNKS + 2) begin
      send_beat(CMD0_WAIT, 1'b0, 1'b0);
      send_beat(8'($urandom_range(0, 8'h33)), 1'b0, 1'b0);
    end
    send_beat(8'($urandom_range(0, 8'h33)), 1'b0, 1'b1);
  endtask

  // Result side backpressure.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !sink_idle_on || ($urandom_range(0, 99) >= 25);
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t seen;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen = '{m_tuser[0], m_tdata[4:0], m_tdata[12:5], m_tdata[20:13],
               m_tdata[26:21], m_tdata[27], m_tlast};
      beats_checked++;
      if (seen.kind == EvTerm) closes_seen++;
      if (expected_events.size() == 0) begin
        note_failure($sformatf("beat %0d with nothing expected: %s",
                               beats_checked, event_text(seen)));
      end else begin
        want = expected_events.pop_front();
        if (seen !== want || m_tdata[31:28] !== 4'd0)
          note_failure($sformatf("beat %0d: expected %s, got %s, fill %h", beats_checked,
                                 event_text(want), event_text(seen), m_tdata[31:28]));
      end
    end
  end

  initial begin : stimulus
    int random_start;
    int phase_start;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed rows.
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].mode !== pred_mode) set_encoding(DIRECTED[i].mode);
      hold_prediction = DIRECTED[i].fixed;
      send_beat(DIRECTED[i].text, DIRECTED[i].first, DIRECTED[i].fin);
      if (DIRECTED[i].fixed_one) expected_events.push_back(DIRECTED[i].fixed_ev);
      hold_prediction = 1'b0;
    end

    // Random phases alternate the encoding; one phase runs with no idling.
    random_start = live_items;
    for (int phase = 0; live_items - random_start < RANDOM_ITEMS; phase++) begin
      set_encoding((phase % 2 == 0) ? MODE_UTF8 : MODE_TABLE);
      src_idle_on  = (phase != 2);
      sink_idle_on = (phase != 2);
      phase_start  = live_items;
      if (phase == 0) send_long_message();
      else if (phase == 1) send_chunk_run();
      while (live_items - phase_start < PHASE_ITEMS &&
             live_items - random_start < RANDOM_ITEMS)
        send_message($urandom_range(0, 4) == 0);
    end

    // Drain.
    s_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_events.size() != 0)
      note_failure($sformatf("%0d results never arrived, first: %s",
                             expected_events.size(), event_text(expected_events[0])));

    $display("Checked %0d result beats, %0d of them chunk closes, from %0d decoded bytes.",
             beats_checked, closes_seen, live_items);
    $display("Both encodings over %0d mode writes; %0d writes fell past the chunk limit.",
             mode_writes, dropped_bytes);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
